/* rtl/core/noise_gate_top_defines.svh */
// Assertion macros shared by the noise gate RTL.
// Every macro expects clk and arst_n in the scope where it is used.
`ifndef NOISE_GATE_TOP_DEFINES_SVH
`define NOISE_GATE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define NG_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define NG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ng_pkg.sv */
// Noise gate package: widths, register indexes, reset values, control structs.
// No dependencies; every other noise gate file but the assertion macro header imports it.
package ng_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_W      = 17;
	localparam int GAIN_W      = 17;
	localparam int THR_W       = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 17;

	// Compare width for envelope against threshold
	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	// Shared multiplier: signed A operand, signed B operand (17-bit unsigned + sign)
	localparam int MULA_W = (SAMPLE_BITS + 1 > COEF_W + 1) ? SAMPLE_BITS + 1 : COEF_W + 1;
	localparam int MULB_W = GAIN_W + 1;
	localparam int PROD_W = MULA_W + MULB_W;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_BITS);
	localparam logic [PROD_W-1:0] ROUND_UP = PROD_W'((1 << FRAC_BITS) - 1);
	localparam logic [SAMPLE_BITS-1:0] PEAK_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_FALL  = CFG_IDX_W'(3);

	// Register reset values
	localparam logic [THR_W-1:0]  RST_OPEN_THRESHOLD = THR_W'(655);
	localparam logic [COEF_W-1:0] RST_ATTACK_STEP    = COEF_W'(1359);
	localparam logic [COEF_W-1:0] RST_RELEASE_STEP   = COEF_W'(14);
	localparam logic [COEF_W-1:0] RST_ENVELOPE_FALL  = COEF_W'(65509);

	typedef struct packed {
		logic [THR_W-1:0]  open_threshold;
		logic [COEF_W-1:0] attack_step;
		logic [COEF_W-1:0] release_step;
		logic [COEF_W-1:0] envelope_fall;
	} ng_cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic ld_in;
		logic env_mul;
		logic gain_mul;
		logic gain_upd;
		logic out_mul;
	} ng_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} ng_sts_t;

	// Coefficients above one act as one
	function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] c);
		return (c > GAIN_ONE) ? GAIN_ONE : c;
	endfunction

endpackage

/* rtl/core/ng_if.sv */
// Noise gate channel interfaces: sample input, sample output, register write.
// Depends on ng_pkg.
interface ng_in_if import ng_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface ng_out_if import ng_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface ng_cfg_if import ng_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/ng_cfg.sv */
// Noise gate configuration register file, written over the config channel.
// Depends on ng_pkg and ng_if.
module ng_cfg import ng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ng_cfg_if.sink      cfg_ch,
	output ng_cfg_t     cfg
);

	ng_cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg = cfg_q;

	// Register write on each config transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_threshold <= RST_OPEN_THRESHOLD;
			cfg_q.attack_step    <= RST_ATTACK_STEP;
			cfg_q.release_step   <= RST_RELEASE_STEP;
			cfg_q.envelope_fall  <= RST_ENVELOPE_FALL;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (cfg_ch.index)
				CFG_OPEN_THRESHOLD: cfg_q.open_threshold <= cfg_ch.data[THR_W-1:0];
				CFG_ATTACK_STEP:    cfg_q.attack_step    <= cfg_ch.data[COEF_W-1:0];
				CFG_RELEASE_STEP:   cfg_q.release_step   <= cfg_ch.data[COEF_W-1:0];
				CFG_ENVELOPE_FALL:  cfg_q.envelope_fall  <= cfg_ch.data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/ng_ctrl.sv */
// Noise gate sequencer: steps each sample through the envelope, gain step, gain update and output passes.
// Depends on ng_pkg.
module ng_ctrl import ng_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  ng_sts_t sts,
	output ng_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ENV  = 5'b00010,
		S_GAIN = 5'b00100,
		S_UPD  = 5'b01000,
		S_OUT  = 5'b10000
	} ng_state_t;

	ng_state_t state_q;
	ng_state_t state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt    = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_nxt = S_ENV;
			end
			S_ENV: begin
				cmd.env_mul = 1'b1;
				state_nxt   = S_GAIN;
			end
			S_GAIN: begin
				cmd.gain_mul = 1'b1;
				state_nxt    = S_UPD;
			end
			S_UPD: begin
				cmd.gain_upd = 1'b1;
				state_nxt    = S_OUT;
			end
			S_OUT: begin
				// result goes out once the output register is free; next sample may enter
				if (sts.out_free) begin
					cmd.out_mul = 1'b1;
					in_ready    = 1'b1;
					state_nxt   = in_valid ? S_ENV : S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
		cmd.ld_in = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* rtl/core/ng_dp.sv */
// Noise gate datapath: envelope, gain smoothing and output scaling on one multiplier.
// Depends on ng_pkg and noise_gate_top_defines.svh.
`include "noise_gate_top_defines.svh"

module ng_dp import ng_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ng_cmd_t                       cmd,
	input  ng_cfg_t                       cfg,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output ng_sts_t                       sts
);

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [SAMPLE_BITS-1:0]        mag_q;
	logic                          jump_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic [SAMPLE_BITS-1:0]        peak_q;
	logic                          open_q;
	logic [GAIN_W-1:0]             gain_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic [SAMPLE_BITS-1:0]   mag;
	logic [SAMPLE_BITS-1:0]   peak_new;
	logic                     open_now;
	logic [GAIN_W-1:0]        gain_d;
	logic [COEF_W-1:0]        att_c;
	logic [COEF_W-1:0]        rel_c;
	logic [COEF_W-1:0]        fall_c;
	logic signed [MULA_W-1:0] mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [PROD_W-1:0]        dn_sum;
	logic [GAIN_W-1:0]        step_up;
	logic [GAIN_W-1:0]        step_dn;

	assign att_c  = clamp_coef(cfg.attack_step);
	assign rel_c  = clamp_coef(cfg.release_step);
	assign fall_c = clamp_coef(cfg.envelope_fall);

	// Magnitude; the most negative sample maps to 2^(N-1), still in range
	assign mag = x_q[SAMPLE_BITS-1] ? (~x_q + SAMPLE_BITS'(1)) : x_q;

	// Envelope after this sample, and gate decision
	assign peak_new = jump_q ? mag_q : prod_q[FRAC_BITS +: SAMPLE_BITS];
	assign open_now = CMP_W'(peak_new) > CMP_W'(cfg.open_threshold);
	assign gain_d   = GAIN_ONE - gain_q;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		priority if (cmd.env_mul) begin
			mul_a = $signed(MULA_W'(peak_q));
			mul_b = $signed(MULB_W'(fall_c));
		end else if (cmd.gain_mul) begin
			mul_a = $signed(MULA_W'(open_now ? att_c : rel_c));
			mul_b = $signed(MULB_W'(open_now ? gain_d : gain_q));
		end else if (cmd.out_mul) begin
			mul_a = MULA_W'(x_q);
			mul_b = $signed(MULB_W'(gain_q));
		end
	end

	assign mul_p = mul_a * mul_b;

	// Gain steps: floor when rising, ceiling magnitude when falling
	assign step_up = prod_q[FRAC_BITS +: GAIN_W];
	assign dn_sum  = prod_q + ROUND_UP;
	assign step_dn = dn_sum[FRAC_BITS +: GAIN_W];

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) x_q <= sample_in;
		if (cmd.env_mul) begin
			mag_q  <= mag;
			jump_q <= mag > peak_q;
		end
		if (cmd.env_mul || cmd.gain_mul) prod_q <= mul_p;
		if (cmd.gain_mul) open_q <= open_now;
		if (cmd.out_mul) out_data_q <= mul_p[FRAC_BITS +: SAMPLE_BITS];
	end

	// Envelope and gain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			gain_q <= '0;
		end else begin
			if (cmd.gain_mul) peak_q <= peak_new;
			if (cmd.gain_upd) gain_q <= open_q ? (gain_q + step_up) : (gain_q - step_dn);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_mul) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = out_data_q;
	assign sts.out_free = !out_valid_q || out_ready;

	`NG_ASSERT_ALWAYS(a_gain_range, gain_q <= GAIN_ONE, "gate gain above unity")
	`NG_ASSERT_ALWAYS(a_peak_range, peak_q <= PEAK_MAX, "envelope above full scale")
	`NG_ASSERT_NEXT(a_out_load, cmd.out_mul, out_valid_q, "result not presented after load")
	`NG_ASSERT_NEXT(a_gain_fall, cmd.gain_upd && !open_q, gain_q <= $past(gain_q), "gain rose while closing")

endmodule

/* rtl/core/noise_gate_top.sv */
// Noise gate top level: peak envelope follower with attack/release gain smoothing.
// Each sample goes through the envelope, gain step, gain update and output states:
// one pass each through the shared 18x18 multiplier (envelope decay, gain step, output
// scaling) plus a gain update. A new sample enters when idle or as the result is loaded.
// Reset: envelope and gain cleared (gate closed), registers back to their default values.
// Depends on ng_pkg, ng_if, ng_cfg, ng_ctrl and ng_dp.
module noise_gate_top import ng_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ng_in_if.sink    in_ch,
	ng_out_if.source out_ch,
	ng_cfg_if.sink   cfg_ch
);

	ng_cfg_t cfg;
	ng_cmd_t cmd;
	ng_sts_t sts;
	logic    in_ready;

	assign in_ch.ready = in_ready;

	ng_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	ng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ng_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sample_in  (in_ch.sample_in),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.sample_out (out_ch.sample_out),
		.sts        (sts)
	);

endmodule
